FILE: hdl/x86_shift_rotate_flags_unit_macros.svh
// Assertion macros for the x86 shift/rotate flags unit.
// Used by modules that check their own pipeline; expects clk and rst in scope.
`ifndef X86_SHIFT_ROTATE_FLAGS_UNIT_MACROS_SVH
`define X86_SHIFT_ROTATE_FLAGS_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define SRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/srf_pkg.sv
// Shared types and codes for the x86 shift/rotate flags unit.
// No dependencies; imported by srf_core and the top level.
package srf_pkg;

  localparam int CNT_W     = 5;
  localparam int SIZE_W    = 6;
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 40;

  localparam logic [2:0] OP_SHL = 3'd0;
  localparam logic [2:0] OP_SAL = 3'd1;
  localparam logic [2:0] OP_SHR = 3'd2;
  localparam logic [2:0] OP_SAR = 3'd3;
  localparam logic [2:0] OP_ROL = 3'd4;
  localparam logic [2:0] OP_ROR = 3'd5;
  localparam logic [2:0] OP_RCL = 3'd6;
  localparam logic [2:0] OP_RCR = 3'd7;

  localparam logic [1:0] WSEL_BYTE  = 2'd0;
  localparam logic [1:0] WSEL_WORD  = 2'd1;
  localparam logic [1:0] WSEL_DWORD = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  width_sel;
    logic [31:0] value;
    logic [7:0]  count;
    logic        cf_in;
    logic        of_in;
    logic        sf_in;
    logic        zf_in;
    logic        pf_in;
  } srf_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        cf_out;
    logic        of_out;
    logic        sf_out;
    logic        zf_out;
    logic        pf_out;
  } srf_result_t;

endpackage

FILE: hdl/srf_core.sv
// Combinational shift/rotate datapath with flag generation.
// Depends on srf_pkg for the item and result types and the operation codes.
module srf_core
  import srf_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  srf_item_t   item,
  output srf_result_t rsl
);

  localparam int W  = MAX_WIDTH;
  localparam int IW = $clog2(W);
  localparam int XW = $clog2(W + 1);
  localparam int DW = $clog2(2 * W);

  logic [SIZE_W-1:0] size_nom;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] wsz;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  r_rot;
  logic [CNT_W-1:0]  r_rc;
  logic [IW-1:0]     msb_idx;
  logic [IW-1:0]     sub_idx;
  logic [W-1:0]      mask;
  logic [W-1:0]      v;
  logic [W-1:0]      sx;
  logic              msb_in;
  logic [2*W-1:0]    shl_wide;
  logic [W:0]        shr_t;
  logic signed [W:0] sar_t;
  logic [W-1:0]      res_shl;
  logic [W-1:0]      res_rol;
  logic [W-1:0]      res_ror;
  logic [W:0]        wmask;
  logic [W:0]        x;
  logic [W:0]        x_rcl;
  logic [W:0]        x_rcr;
  logic [W-1:0]      res;
  logic              is_shift;

  function automatic logic [CNT_W-1:0] cnt_mod(input logic [CNT_W-1:0] c,
                                               input logic [SIZE_W-1:0] m);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(c);
    for (int i = 0; i < 3; i++) begin
      if (r >= m) begin
        r = r - m;
      end
    end
    return CNT_W'(r);
  endfunction

  always_comb begin
    unique case (item.width_sel)
      WSEL_BYTE: size_nom = SIZE_W'(8);
      WSEL_WORD: size_nom = SIZE_W'(16);
      default:   size_nom = SIZE_W'(32);
    endcase
  end

  assign size    = (size_nom > SIZE_W'(W)) ? SIZE_W'(W) : size_nom;
  assign wsz     = size + SIZE_W'(1);
  assign cnt     = item.count[CNT_W-1:0];
  assign msb_idx = IW'(size - SIZE_W'(1));
  assign sub_idx = IW'(size - SIZE_W'(2));
  assign mask    = {W{1'b1}} >> (SIZE_W'(W) - size);
  assign wmask   = {(W + 1){1'b1}} >> (SIZE_W'(W) - size);
  assign v       = item.value[W-1:0] & mask;
  assign msb_in  = v[msb_idx];
  assign sx      = msb_in ? (v | ~mask) : v;

  assign shl_wide = {{W{1'b0}}, v} << cnt;
  assign res_shl  = shl_wide[W-1:0] & mask;
  assign shr_t    = {v, 1'b0} >> cnt;
  assign sar_t    = $signed({sx, 1'b0}) >>> cnt;

  assign r_rot   = cnt_mod(cnt, size);
  assign r_rc    = cnt_mod(cnt, wsz);
  assign res_rol = (r_rot == '0) ? v :
                   (((v << r_rot) | (v >> (size - SIZE_W'(r_rot)))) & mask);
  assign res_ror = (r_rot == '0) ? v :
                   (((v >> r_rot) | (v << (size - SIZE_W'(r_rot)))) & mask);

  assign x     = {1'b0, v} | ((W + 1)'(item.cf_in) << size);
  assign x_rcl = ((x << r_rc) | (x >> (wsz - SIZE_W'(r_rc)))) & wmask;
  assign x_rcr = ((x >> r_rc) | (x << (wsz - SIZE_W'(r_rc)))) & wmask;

  assign is_shift = (item.op == OP_SHL) || (item.op == OP_SAL) ||
                    (item.op == OP_SHR) || (item.op == OP_SAR);

  always_comb begin
    res        = v;
    rsl.cf_out = item.cf_in;
    rsl.of_out = item.of_in;
    rsl.sf_out = item.sf_in;
    rsl.zf_out = item.zf_in;
    rsl.pf_out = item.pf_in;
    if (cnt != '0) begin
      unique case (item.op) inside
        OP_SHL, OP_SAL: begin
          res        = res_shl;
          rsl.cf_out = shl_wide[DW'(size)];
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = res_shl[msb_idx] ^ shl_wide[DW'(size)];
          end
        end
        OP_SHR: begin
          res        = shr_t[W:1];
          rsl.cf_out = shr_t[0];
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = msb_in;
          end
        end
        OP_SAR: begin
          res        = sar_t[W:1] & mask;
          rsl.cf_out = sar_t[0];
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = 1'b0;
          end
        end
        OP_ROL: begin
          res        = res_rol;
          rsl.cf_out = res_rol[0];
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = res_rol[0] ^ res_rol[msb_idx];
          end
        end
        OP_ROR: begin
          res        = res_ror;
          rsl.cf_out = res_ror[msb_idx];
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = res_ror[msb_idx] ^ res_ror[sub_idx];
          end
        end
        OP_RCL: begin
          if (r_rc != '0) begin
            res        = x_rcl[W-1:0] & mask;
            rsl.cf_out = x_rcl[XW'(size)];
          end
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = rsl.cf_out ^ res[msb_idx];
          end
        end
        OP_RCR: begin
          if (cnt == CNT_W'(1)) begin
            rsl.of_out = msb_in ^ item.cf_in;
          end
          if (r_rc != '0) begin
            res        = x_rcr[W-1:0] & mask;
            rsl.cf_out = x_rcr[XW'(size)];
          end
        end
      endcase
      if (is_shift) begin
        rsl.sf_out = res[msb_idx];
        rsl.zf_out = (res == '0);
        rsl.pf_out = ~^res[7:0];
      end
    end
    rsl.result = 32'(res);
  end

endmodule

FILE: hdl/x86_shift_rotate_flags_unit.sv
// An accepted item goes into the input register, and its result into the result register.
// Throughput: one item per cycle while not stalled; the barrel shifters between the registers set the path.
// Ready drops only when both registers are full and the result is not being taken.
// Reset (rst, synchronous, active high) clears both valid bits; no payload is reset.
// Top level of the x86 shift/rotate flags unit; depends on srf_pkg, srf_core and
// x86_shift_rotate_flags_unit_macros.svh.
`include "x86_shift_rotate_flags_unit_macros.svh"

module x86_shift_rotate_flags_unit
  import srf_pkg::*;
#(
  parameter int MAX_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // value[31:0], count[39:32], cf_in[40], of_in[41], sf_in[42], zf_in[43], pf_in[44], zero
  input  logic [S_TDATA_W-1:0] s_tdata,
  // op[2:0], width_sel[4:3]
  input  logic [S_TUSER_W-1:0] s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // result[31:0], cf_out[32], of_out[33], sf_out[34], zf_out[35], pf_out[36], zero
  output logic [M_TDATA_W-1:0] m_tdata
);

  srf_item_t   in_d;
  srf_item_t   in_q;
  logic        v1;
  logic        ready1;
  logic        ready2;
  srf_result_t core_rsl;
  srf_result_t out_q;
  logic        load2;
  logic        rot_q;
  logic        zcnt_q;
  logic        byte_q;
  logic [2:0]  szp_q;
  logic [2:0]  out_szp;

  assign in_d.op        = s_tuser[2:0];
  assign in_d.width_sel = s_tuser[4:3];
  assign in_d.value     = s_tdata[31:0];
  assign in_d.count     = s_tdata[39:32];
  assign in_d.cf_in     = s_tdata[40];
  assign in_d.of_in     = s_tdata[41];
  assign in_d.sf_in     = s_tdata[42];
  assign in_d.zf_in     = s_tdata[43];
  assign in_d.pf_in     = s_tdata[44];

  assign ready2   = !m_tvalid || m_tready;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && ready1) begin
      in_q <= in_d;
    end
  end

  srf_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_core (
    .item(in_q),
    .rsl (core_rsl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready2) begin
      m_tvalid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      out_q <= core_rsl;
    end
  end

  assign m_tdata = {3'b000, out_q.pf_out, out_q.zf_out, out_q.sf_out,
                    out_q.of_out, out_q.cf_out, out_q.result};

  assign load2   = v1 && ready2;
  assign rot_q   = in_q.op inside {OP_ROL, OP_ROR, OP_RCL, OP_RCR};
  assign zcnt_q  = (in_q.count[CNT_W-1:0] == '0);
  assign byte_q  = (in_q.width_sel == WSEL_BYTE);
  assign szp_q   = {in_q.sf_in, in_q.zf_in, in_q.pf_in};
  assign out_szp = {out_q.sf_out, out_q.zf_out, out_q.pf_out};

  `SRF_ASSERT_NXT(a_item_lands, s_tvalid && s_tready, v1, "accepted item not held")
  `SRF_ASSERT_NXT(a_zero_cnt_cf, load2 && zcnt_q, out_q.cf_out == $past(in_q.cf_in), "CF changed")
  `SRF_ASSERT_NXT(a_rot_keeps_szp, load2 && rot_q, out_szp == $past(szp_q), "SF/ZF/PF changed")
  `SRF_ASSERT_NXT(a_byte_upper_zero, load2 && byte_q, out_q.result[31:8] == '0, "upper bits set")
  `SRF_ASSERT_IMP(a_out_fill, m_tvalid && !m_tready, !s_tready || !v1, "accept while full")

endmodule
